// ===== hw/rtl/floyd_closeness_sums_defines.svh =====
// Assertion macros for the closeness-sum block.
// Used by the top level only; no dependencies.
`ifndef FLOYD_CLOSENESS_SUMS_DEFINES_SVH
`define FLOYD_CLOSENESS_SUMS_DEFINES_SVH

`ifndef SYNTH
// Plain property, checked on every clock edge outside reset.
`define FCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication, same cycle.
`define FCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication, next cycle.
`define FCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FCS_ASSERT(lbl, prop, msg)
`define FCS_ASSERT_IMP(lbl, ante, cons, msg)
`define FCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/fcs_pkg.sv =====
// Shared types and constants for the closeness-sum block.
// No dependencies; imported by the controller, datapath and top level.
package fcs_pkg;

  localparam int NODE_W         = 6;
  localparam int SUM_W          = 21;
  localparam int DIST_W         = 15;
  localparam int CFG_W          = 7;
  localparam int LIMIT_NODES    = 64;
  localparam int MAX_NODES_DEF  = 64;
  localparam logic [DIST_W-1:0] NO_PATH        = 15'h7FFF;
  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [SUM_W-1:0]  distance_sum;
    logic              last_node;
  } result_item_t;

  // Memory operation issued by the controller in a cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_EDGE,
    OP_CLEAR,
    OP_FETCH,
    OP_RELAX,
    OP_SUM
  } op_e;

  typedef struct packed {
    op_e  op;
    logic first;   // first column of a row sum
    logic emit;    // load the row sum into the output register
    logic last;    // row being emitted is the final node
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/fcs_ctrl.sv =====
// Sequencer for the closeness-sum block: edge load, relaxation, readout, clear.
// Depends on fcs_pkg; drives the datapath through cmd_t and the loop counters.
module fcs_ctrl import fcs_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  clk_i,
  rst_ni,
  in_valid_i,
  in_last_i,
  in_ready_o,
  cfg_we_i,
  cfg_data_i,
  status_i,
  cmd_o,
  piv_o,
  row_o,
  col_o,
  clr_addr_o
);
  localparam int ACT_MAX = (MAX_NODES < LIMIT_NODES) ? MAX_NODES : LIMIT_NODES;
  localparam int CNT_W   = $clog2(ACT_MAX);
  localparam int NW      = $clog2(ACT_MAX + 1);
  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int ADDR_W  = 2 * IDX_W;

  input  logic              clk_i;
  input  logic              rst_ni;
  input  logic              in_valid_i;
  input  logic              in_last_i;
  output logic              in_ready_o;
  input  logic              cfg_we_i;
  input  logic [CFG_W-1:0]  cfg_data_i;
  input  status_t           status_i;
  output cmd_t              cmd_o;
  output logic [CNT_W-1:0]  piv_o;
  output logic [CNT_W-1:0]  row_o;
  output logic [CNT_W-1:0]  col_o;
  output logic [ADDR_W-1:0] clr_addr_o;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_FETCH,
    ST_RELAX,
    ST_SUM,
    ST_SUM_WAIT,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   piv_q, piv_d;
  logic [CNT_W-1:0]   row_q, row_d;
  logic [CNT_W-1:0]   col_q, col_d;
  logic [NW-1:0]      n_q, n_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [CFG_W-1:0]   node_count_q, node_count_d;
  logic [NW-1:0]      run_n;

  function automatic logic at_end(input logic [CNT_W-1:0] c, input logic [NW-1:0] n);
    return (NW'(c) + NW'(1)) == n;
  endfunction

  // Saturate the node count to what the matrix holds
  assign run_n = (node_count_q > CFG_W'(ACT_MAX)) ? NW'(ACT_MAX) : NW'(node_count_q);

  always_comb begin
    state_d      = state_q;
    piv_d        = piv_q;
    row_d        = row_q;
    col_d        = col_q;
    n_d          = n_q;
    clr_d        = clr_q;
    node_count_d = cfg_we_i ? cfg_data_i : node_count_q;
    cmd_o        = '{op: OP_IDLE, first: 1'b0, emit: 1'b0, last: 1'b0};
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        clr_d    = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.op = OP_EDGE;
          if (in_last_i) begin
            n_d     = run_n;
            state_d = (run_n == '0) ? ST_CLEAR : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.op = OP_FETCH;
        col_d    = row_q;   // upper triangle only: start each row on the diagonal
        state_d  = ST_RELAX;
      end
      ST_RELAX: begin
        cmd_o.op = OP_RELAX;
        if (at_end(col_q, n_q)) begin
          col_d = '0;
          if (at_end(row_q, n_q)) begin
            row_d = '0;
            if (at_end(piv_q, n_q)) begin
              piv_d   = '0;
              state_d = ST_SUM;
            end else begin
              piv_d   = piv_q + CNT_W'(1);
              state_d = ST_FETCH;
            end
          end else begin
            row_d   = row_q + CNT_W'(1);
            state_d = ST_FETCH;
          end
        end else begin
          col_d = col_q + CNT_W'(1);
        end
      end
      ST_SUM: begin
        cmd_o.op    = OP_SUM;
        cmd_o.first = (col_q == '0);
        if (at_end(col_q, n_q)) begin
          col_d   = '0;
          state_d = ST_SUM_WAIT;
        end else begin
          col_d = col_q + CNT_W'(1);
        end
      end
      ST_SUM_WAIT: begin
        // let the last read of the row reach the accumulator
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = at_end(row_q, n_q);
        if (status_i.out_free) begin
          if (at_end(row_q, n_q)) begin
            row_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            row_d   = row_q + CNT_W'(1);
            state_d = ST_SUM;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      piv_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      n_q          <= '0;
      clr_q        <= '0;
      node_count_q <= NODE_COUNT_RST;
    end else begin
      state_q      <= state_d;
      piv_q        <= piv_d;
      row_q        <= row_d;
      col_q        <= col_d;
      n_q          <= n_d;
      clr_q        <= clr_d;
      node_count_q <= node_count_d;
    end
  end

  assign in_ready_o = (state_q == ST_LOAD);
  assign piv_o      = piv_q;
  assign row_o      = row_q;
  assign col_o      = col_q;
  assign clr_addr_o = clr_q;

endmodule

// ===== hw/rtl/fcs_datapath.sv =====
// Datapath for the closeness-sum block: distance memory, relax compare,
// row accumulator and output register. Depends on fcs_pkg.
module fcs_datapath import fcs_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  clk_i,
  rst_ni,
  in_item_i,
  cmd_i,
  piv_i,
  row_i,
  col_i,
  clr_addr_i,
  status_o,
  out_valid_o,
  out_ready_i,
  out_item_o
);
  localparam int ACT_MAX = (MAX_NODES < LIMIT_NODES) ? MAX_NODES : LIMIT_NODES;
  localparam int CNT_W   = $clog2(ACT_MAX);
  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int ADDR_W  = 2 * IDX_W;

  input  logic              clk_i;
  input  logic              rst_ni;
  input  edge_item_t        in_item_i;
  input  cmd_t              cmd_i;
  input  logic [CNT_W-1:0]  piv_i;
  input  logic [CNT_W-1:0]  row_i;
  input  logic [CNT_W-1:0]  col_i;
  input  logic [ADDR_W-1:0] clr_addr_i;
  output status_t           status_o;
  output logic              out_valid_o;
  input  logic              out_ready_i;
  output result_item_t      out_item_o;

  // The matrix stays symmetric, so only the entry with row <= column is kept
  function automatic logic [ADDR_W-1:0] canon(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
    return (r <= c) ? {r, c} : {c, r};
  endfunction

  logic [DIST_W-1:0] dist_mem_q [2**ADDR_W];
  logic [DIST_W-1:0] rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DIST_W-1:0] wr_data;
  logic              wr_en;
  logic [ADDR_W-1:0] relax_addr_q;
  op_e               op_q;
  logic              first_q;
  logic [DIST_W-1:0] ik_q;
  logic [DIST_W:0]   through;
  logic              relax_we;
  logic [SUM_W-1:0]  acc_q;
  logic              out_valid_q;
  result_item_t      out_q;
  logic              edge_ok;
  logic [IDX_W-1:0]  piv_x, row_x, col_x;

  assign piv_x = IDX_W'(piv_i);
  assign row_x = IDX_W'(row_i);
  assign col_x = IDX_W'(col_i);

  always_comb begin
    case (cmd_i.op)
      OP_FETCH: rd_a_addr = canon(row_x, piv_x);
      OP_RELAX: rd_a_addr = canon(piv_x, col_x);
      OP_SUM:   rd_a_addr = canon(row_x, col_x);
      default:  rd_a_addr = '0;
    endcase
  end
  assign rd_b_addr = canon(row_x, col_x);

  // Drop edges whose endpoints fall outside the matrix
  assign edge_ok = (32'(in_item_i.node_a) < MAX_NODES) && (32'(in_item_i.node_b) < MAX_NODES);

  assign through  = {1'b0, ik_q} + {1'b0, rd_a_q};
  assign relax_we = (op_q == OP_RELAX) && ({1'b0, rd_b_q} > through);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = relax_addr_q;
    wr_data = through[DIST_W-1:0];
    if (cmd_i.op == OP_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_i;
      wr_data = NO_PATH;
    end else if (cmd_i.op == OP_EDGE) begin
      wr_en   = edge_ok;
      wr_addr = canon(IDX_W'(in_item_i.node_a), IDX_W'(in_item_i.node_b));
      wr_data = DIST_W'(1);
    end else if (relax_we) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dist_mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= dist_mem_q[rd_a_addr];
    rd_b_q <= dist_mem_q[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      op_q <= cmd_i.op;
      if (cmd_i.emit && status_o.out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q      <= cmd_i.first;
    relax_addr_q <= rd_b_addr;
    if (op_q == OP_FETCH) begin
      ik_q <= rd_a_q;
    end
    if (op_q == OP_SUM) begin
      acc_q <= (first_q ? '0 : acc_q) + SUM_W'(rd_a_q);
    end
    if (cmd_i.emit && status_o.out_free) begin
      out_q.node_index   <= NODE_W'(row_i);
      out_q.distance_sum <= acc_q;
      out_q.last_node    <= cmd_i.last;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

// ===== hw/rtl/floyd_closeness_sums.sv =====
// Top level of the closeness-sum block: controller plus datapath.
// Depends on fcs_pkg, fcs_ctrl, fcs_datapath and floyd_closeness_sums_defines.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_item_i   (edge_item_t)
//  out     | output    | out_valid_o/out_ready_i| out_item_o  (result_item_t)
//  cfg     | input     | cfg_we_i, no wait      | cfg_data_i  (node_count)
//
// Edges load at one item per cycle while in_ready_o is high; one write port
// writes the single stored entry of each symmetric pair. The final edge
// starts the relaxation run (a row fetch, then the upper triangle of each
// row, one entry per cycle on two read ports), then the readout, which can
// stall on the output. After reset and after every run the memory is
// cleared one entry a cycle; no edge is taken meanwhile, configuration
// writes are.
`include "floyd_closeness_sums_defines.svh"

module floyd_closeness_sums import fcs_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  edge_item_t       in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_item_t     out_item_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i
);
  localparam int ACT_MAX = (MAX_NODES < LIMIT_NODES) ? MAX_NODES : LIMIT_NODES;
  localparam int CNT_W   = $clog2(ACT_MAX);
  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int ADDR_W  = 2 * IDX_W;

  cmd_t              cmd;
  status_t           status;
  logic [CNT_W-1:0]  piv, row, col;
  logic [ADDR_W-1:0] clr_addr;

  fcs_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last_edge),
    .in_ready_o (in_ready_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .piv_o      (piv),
    .row_o      (row),
    .col_o      (col),
    .clr_addr_o (clr_addr)
  );

  fcs_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .piv_i       (piv),
    .row_i       (row),
    .col_i       (col),
    .clr_addr_i  (clr_addr),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Loop counters rest at zero while edges load
  `FCS_ASSERT_IMP(a_idle_counters, in_ready_o, piv == '0 && row == '0 && col == '0, "counters not zero during edge load")
  // Relaxation walks the upper triangle only
  `FCS_ASSERT_IMP(a_relax_upper, cmd.op == OP_RELAX, col >= row, "relax step below the diagonal")
  // An emitted row sum appears on the output with its node and last flag
  `FCS_ASSERT_NXT(a_emit_loads, cmd.emit && status.out_free, out_valid_o && out_item_o.node_index == NODE_W'($past(row)) && out_item_o.last_node == $past(cmd.last), "row sum not loaded into output")
  // No edge is taken while the memory is busy with a run or a clear
  `FCS_ASSERT(a_no_edge_busy, !in_ready_o || (!cmd.emit && cmd.op != OP_CLEAR && cmd.op != OP_RELAX), "edge accepted while busy")

endmodule
